FILE: rtl/three_plane_intersection_core_assert.svh
// Assertion helpers for the intersection core.
`ifndef THREE_PLANE_INTERSECTION_CORE_ASSERT_SVH
`define THREE_PLANE_INTERSECTION_CORE_ASSERT_SVH

// Same-cycle implication.
`define TPI_ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tpi check failed");

// Next-cycle implication.
`define TPI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tpi check failed");

`endif

FILE: rtl/tpi_pkg.sv
package tpi_pkg;

	localparam int NRM_W = 16;
	localparam int DST_W = 32;
	localparam int CRD_W = 32;
	localparam int THR_W = 32;
	localparam int U_W   = 2 * NRM_W + 1;
	localparam int V_W   = NRM_W + DST_W + 1;
	localparam int TD_W  = NRM_W + U_W;
	localparam int TX_W  = DST_W + U_W;
	localparam int TV_W  = NRM_W + V_W;
	localparam int DET_W = TD_W + 2;
	localparam int NUM_W = TX_W + 3;
	localparam int Q_W   = CRD_W + 1;
	localparam int FRONT_STAGES = 6;
	localparam int FIFO_DEPTH = 2;

	localparam logic [THR_W-1:0] THR_RESET = 32'd4398047;
	localparam logic [Q_W-1:0] LIM_POS = 33'h07FFFFFFF;
	localparam logic [Q_W-1:0] LIM_NEG = 33'h080000000;

	typedef struct packed {
		logic signed [NRM_W-1:0] plane1_normal_x;
		logic signed [NRM_W-1:0] plane1_normal_y;
		logic signed [NRM_W-1:0] plane1_normal_z;
		logic signed [DST_W-1:0] plane1_distance;
		logic signed [NRM_W-1:0] plane2_normal_x;
		logic signed [NRM_W-1:0] plane2_normal_y;
		logic signed [NRM_W-1:0] plane2_normal_z;
		logic signed [DST_W-1:0] plane2_distance;
		logic signed [NRM_W-1:0] plane3_normal_x;
		logic signed [NRM_W-1:0] plane3_normal_y;
		logic signed [NRM_W-1:0] plane3_normal_z;
		logic signed [DST_W-1:0] plane3_distance;
	} plane_set_t;

	typedef struct packed {
		logic                    found;
		logic signed [CRD_W-1:0] point_x;
		logic signed [CRD_W-1:0] point_y;
		logic signed [CRD_W-1:0] point_z;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic       found;
		logic [2:0] neg;
	} side_t;

endpackage

FILE: rtl/tpi_if.sv
interface tpi_req_if;
	import tpi_pkg::*;
	logic       valid;
	logic       ready;
	plane_set_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tpi_rsp_if;
	import tpi_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/tpi_front.sv
module tpi_front #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                                           clk,
	input  logic                                           en,
	input  logic [tpi_pkg::THR_W-1:0]                      thr,
	input  tpi_pkg::plane_set_t                            din,
	output logic [tpi_pkg::NUM_W+NORMAL_FRAC_BITS:0]       mag [3],
	output logic [tpi_pkg::DET_W-1:0]                      dm,
	output tpi_pkg::side_t                                 side
);
	import tpi_pkg::*;

	localparam int SNUM_W = NUM_W + NORMAL_FRAC_BITS;
	localparam int MAG_W  = SNUM_W + 1;

	logic signed [2*NRM_W-1:0]     pu_s1 [6];
	logic signed [NRM_W+DST_W-1:0] pv_s1 [6];
	plane_set_t                    pl_s1, pl_s2;
	logic signed [U_W-1:0]         u_s2 [3];
	logic signed [V_W-1:0]         v_s2 [3];
	logic signed [TD_W-1:0]        td_s3 [3];
	logic signed [TX_W-1:0]        tx_s3 [3];
	logic signed [TV_W-1:0]        ty_s3 [3];
	logic signed [TV_W-1:0]        tz_s3 [3];
	logic signed [DET_W-1:0]       det_s4;
	logic signed [NUM_W-1:0]       num_s4 [3];
	logic [DET_W-1:0]              dm_s5, dm_s6;
	logic [SNUM_W-1:0]             an_s5 [3];
	logic [2:0]                    neg_s5;
	logic [MAG_W-1:0]              mag_s6 [3];
	side_t                         side_s6;
	logic signed [SNUM_W-1:0]      sn [3];
	logic                          dneg;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= din;
			pu_s1[0] <= din.plane2_normal_y * din.plane3_normal_z;
			pu_s1[1] <= din.plane3_normal_y * din.plane2_normal_z;
			pu_s1[2] <= din.plane3_normal_y * din.plane1_normal_z;
			pu_s1[3] <= din.plane1_normal_y * din.plane3_normal_z;
			pu_s1[4] <= din.plane1_normal_y * din.plane2_normal_z;
			pu_s1[5] <= din.plane2_normal_y * din.plane1_normal_z;
			pv_s1[0] <= din.plane2_normal_x * din.plane3_distance;
			pv_s1[1] <= din.plane3_normal_x * din.plane2_distance;
			pv_s1[2] <= din.plane3_normal_x * din.plane1_distance;
			pv_s1[3] <= din.plane1_normal_x * din.plane3_distance;
			pv_s1[4] <= din.plane1_normal_x * din.plane2_distance;
			pv_s1[5] <= din.plane2_normal_x * din.plane1_distance;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2 <= pl_s1;
			for (int i = 0; i < 3; i++) begin
				u_s2[i] <= U_W'(pu_s1[2*i]) - U_W'(pu_s1[2*i+1]);
				v_s2[i] <= V_W'(pv_s1[2*i]) - V_W'(pv_s1[2*i+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			td_s3[0] <= pl_s2.plane1_normal_x * u_s2[0];
			td_s3[1] <= pl_s2.plane2_normal_x * u_s2[1];
			td_s3[2] <= pl_s2.plane3_normal_x * u_s2[2];
			tx_s3[0] <= pl_s2.plane1_distance * u_s2[0];
			tx_s3[1] <= pl_s2.plane2_distance * u_s2[1];
			tx_s3[2] <= pl_s2.plane3_distance * u_s2[2];
			ty_s3[0] <= pl_s2.plane1_normal_z * v_s2[0];
			ty_s3[1] <= pl_s2.plane2_normal_z * v_s2[1];
			ty_s3[2] <= pl_s2.plane3_normal_z * v_s2[2];
			tz_s3[0] <= pl_s2.plane1_normal_y * v_s2[0];
			tz_s3[1] <= pl_s2.plane2_normal_y * v_s2[1];
			tz_s3[2] <= pl_s2.plane3_normal_y * v_s2[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= DET_W'(td_s3[0]) + DET_W'(td_s3[1]) + DET_W'(td_s3[2]);
			num_s4[0] <= NUM_W'(tx_s3[0]) + NUM_W'(tx_s3[1]) + NUM_W'(tx_s3[2]);
			num_s4[1] <= NUM_W'(ty_s3[0]) + NUM_W'(ty_s3[1]) + NUM_W'(ty_s3[2]);
			num_s4[2] <= NUM_W'(0) - (NUM_W'(tz_s3[0]) + NUM_W'(tz_s3[1])
				+ NUM_W'(tz_s3[2]));
		end
	end

	always_comb begin
		dneg = det_s4[DET_W-1];
		for (int i = 0; i < 3; i++) begin
			sn[i] = SNUM_W'(num_s4[i]) <<< NORMAL_FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s5 <= dneg ? DET_W'(-det_s4) : DET_W'(det_s4);
			for (int i = 0; i < 3; i++) begin
				an_s5[i] <= num_s4[i][NUM_W-1] ? SNUM_W'(-sn[i]) : SNUM_W'(sn[i]);
				neg_s5[i] <= num_s4[i][NUM_W-1] ^ dneg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s6 <= dm_s5;
			side_s6.found <= dm_s5 > DET_W'(thr);
			side_s6.neg <= neg_s5;
			for (int i = 0; i < 3; i++) begin
				mag_s6[i] <= MAG_W'(an_s5[i]) + MAG_W'(dm_s5[DET_W-1:1]);
			end
		end
	end

	assign mag  = mag_s6;
	assign dm   = dm_s6;
	assign side = side_s6;

endmodule

FILE: rtl/tpi_div.sv
module tpi_div #(
	parameter int MAG_W = 83,
	parameter int DEN_W = 51,
	parameter int Q_W   = 33
) (
	input  logic             clk,
	input  logic             en,
	input  logic [MAG_W-1:0] mag,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);
	localparam int H_W   = MAG_W - Q_W;
	localparam int CMP_W = (H_W > DEN_W) ? H_W + 1 : DEN_W + 1;

	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   low_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	logic             ovf_s [Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CMP_W'(mag[MAG_W-1:Q_W]) >= CMP_W'(den);
			rem_s[0] <= DEN_W'(mag[MAG_W-1:Q_W]);
			low_s[0] <= mag[Q_W-1:0];
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DEN_W:0] t;
		logic           ge;
		assign t  = {rem_s[k-1], low_s[k-1][Q_W-1]};
		assign ge = t >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]   <= {q_s[k-1][Q_W-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < Q_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? DEN_W'(t - {1'b0, den_s[k-1]}) : DEN_W'(t);
					low_s[k] <= {low_s[k-1][Q_W-2:0], 1'b0};
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = q_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

FILE: rtl/three_plane_intersection_core.sv
// Throughput: one plane triple per cycle; six arithmetic stages feed three
// one-bit-per-stage divider lanes of 34 stages, then a two-entry output FIFO.
// Input stalls only while that FIFO is full.
// Reset clears all valid bits and the FIFO and sets the threshold thr_q to 4398047.
module three_plane_intersection_core #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [tpi_pkg::THR_W-1:0] cfg_wr_data,
	tpi_req_if.sink                   req,
	tpi_rsp_if.source                 rsp
);
	import tpi_pkg::*;

	`include "three_plane_intersection_core_assert.svh"

	localparam int MAG_W = NUM_W + NORMAL_FRAC_BITS + 1;
	localparam int LAT   = FRONT_STAGES + Q_W + 1;

	logic [THR_W-1:0] thr_q;
	logic             adv;
	logic [LAT-1:0]   vld_s;
	logic [MAG_W-1:0] mag [3];
	logic [DET_W-1:0] dm;
	side_t            side_f;
	side_t            side_s [Q_W+1];
	logic [Q_W-1:0]   quo [3];
	logic [2:0]       ovf;
	logic [2:0]       sat;
	logic [Q_W-1:0]   lim [3];
	logic [CRD_W-1:0] cmag [3];
	logic [CRD_W-1:0] crd [3];
	result_t          res;

	result_t          fifo_q [FIFO_DEPTH];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fifo_cnt_q;
	logic             push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	assign adv = fifo_cnt_q != 2'(FIFO_DEPTH);
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], req.valid};
		end
	end

	tpi_front #(
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_front (
		.clk (clk),
		.en  (adv),
		.thr (thr_q),
		.din (req.data),
		.mag (mag),
		.dm  (dm),
		.side(side_f)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		tpi_div #(
			.MAG_W(MAG_W),
			.DEN_W(DET_W),
			.Q_W  (Q_W)
		) u_div (
			.clk(clk),
			.en (adv),
			.mag(mag[i]),
			.den(dm),
			.quo(quo[i]),
			.ovf(ovf[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_f;
			for (int k = 1; k <= Q_W; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lim[i]  = side_s[Q_W].neg[i] ? LIM_NEG : LIM_POS;
			sat[i]  = ovf[i] | (quo[i] > lim[i]);
			cmag[i] = sat[i] ? lim[i][CRD_W-1:0] : quo[i][CRD_W-1:0];
			crd[i]  = side_s[Q_W].neg[i] ? CRD_W'(0) - cmag[i] : cmag[i];
		end
		res.found     = side_s[Q_W].found;
		res.point_x   = side_s[Q_W].found ? crd[0] : '0;
		res.point_y   = side_s[Q_W].found ? crd[1] : '0;
		res.point_z   = side_s[Q_W].found ? crd[2] : '0;
		res.saturated = side_s[Q_W].found & (|sat);
	end

	assign push = adv & vld_s[LAT-1];
	assign pop  = rsp.valid & rsp.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fifo_cnt_q <= fifo_cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign rsp.valid = fifo_cnt_q != '0;
	assign rsp.data  = fifo_q[rd_ptr_q];

	`TPI_ASSERT_IMPLIES(a_fifo_bound, clk, arst_n, 1'b1, fifo_cnt_q <= 2'(FIFO_DEPTH))
	`TPI_ASSERT_IMPLIES(a_miss_zero, clk, arst_n, rsp.valid && !rsp.data.found, rsp.data.point_x == '0 && rsp.data.point_y == '0 && rsp.data.point_z == '0 && !rsp.data.saturated)
	`TPI_ASSERT_NEXT(a_stall_hold, clk, arst_n, !adv, $stable(vld_s))

endmodule

FILE: sim/three_plane_intersection_core_tb.sv
`timescale 1ns / 1ps

module three_plane_intersection_core_tb;
	import tpi_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF = 300;
	localparam int ITEMS_PER_PHASE = 315;
	localparam int SET_W = $bits(plane_set_t);
	localparam logic [THR_W-1:0] THR_MAX = '1;

	typedef struct {
		plane_set_t planes;
		bit         typed;
		result_t    want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [THR_W-1:0] cfg_wr_data = '0;

	tpi_req_if req ();
	tpi_rsp_if rsp ();

	three_plane_intersection_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req),
		.rsp(rsp)
	);

	logic [THR_W-1:0] threshold = THR_RESET;
	result_t pending_points[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_rsp = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [CRD_W-1:0] round_divide(input logic signed [127:0] num,
			input logic signed [127:0] det, inout bit sat);
		logic [127:0] mag;
		logic [127:0] dmag;
		logic [127:0] q;
		logic [127:0] lim;
		bit neg_out;
		num = num <<< 14;
		mag = (num < 0) ? -num : num;
		dmag = (det < 0) ? -det : det;
		mag = mag + (dmag >> 1);
		q = mag / dmag;
		neg_out = (num < 0) ^ (det < 0);
		lim = neg_out ? 128'h80000000 : 128'h7FFFFFFF;
		if (q > lim) begin
			sat = 1;
			q = lim;
		end
		return neg_out ? -q[CRD_W-1:0] : q[CRD_W-1:0];
	endfunction

	function automatic result_t solve_planes(input plane_set_t p, input logic [THR_W-1:0] thr);
		logic signed [127:0] ax, ay, az, ad, bx, by, bz, bd, cx, cy, cz, cd;
		logic signed [127:0] u0, u1, u2, v0, v1, v2, det;
		logic [127:0] dmag;
		result_t r;
		bit sat;
		ax = p.plane1_normal_x; ay = p.plane1_normal_y; az = p.plane1_normal_z;
		ad = p.plane1_distance;
		bx = p.plane2_normal_x; by = p.plane2_normal_y; bz = p.plane2_normal_z;
		bd = p.plane2_distance;
		cx = p.plane3_normal_x; cy = p.plane3_normal_y; cz = p.plane3_normal_z;
		cd = p.plane3_distance;
		r = '0;
		sat = 0;
		u0 = by * cz - cy * bz;
		u1 = cy * az - ay * cz;
		u2 = ay * bz - by * az;
		det = ax * u0 + bx * u1 + cx * u2;
		dmag = (det < 0) ? -det : det;
		if (dmag <= {96'd0, thr})
			return r;
		v0 = bx * cd - cx * bd;
		v1 = cx * ad - ax * cd;
		v2 = ax * bd - bx * ad;
		r.found = 1'b1;
		r.point_x = round_divide(ad * u0 + bd * u1 + cd * u2, det, sat);
		r.point_y = round_divide(az * v0 + bz * v1 + cz * v2, det, sat);
		r.point_z = round_divide(-(ay * v0 + by * v1 + cy * v2), det, sat);
		r.saturated = sat;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic plane_set_t axis_planes(input logic signed [15:0] n,
			input logic signed [31:0] d1, d2, d3);
		plane_set_t p;
		p = '0;
		p.plane1_normal_x = n; p.plane2_normal_y = n; p.plane3_normal_z = n;
		p.plane1_distance = d1; p.plane2_distance = d2; p.plane3_distance = d3;
		return p;
	endfunction

	function automatic plane_set_t random_planes();
		plane_set_t p;
		int mode;
		int sh;
		p = SET_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		mode = $urandom_range(0, 9);
		case (mode)
		5, 6: begin
			sh = $urandom_range(2, 12);
			p.plane1_normal_x = p.plane1_normal_x >>> sh;
			p.plane1_normal_y = p.plane1_normal_y >>> sh;
			p.plane1_normal_z = p.plane1_normal_z >>> sh;
			p.plane2_normal_x = p.plane2_normal_x >>> sh;
			p.plane2_normal_y = p.plane2_normal_y >>> sh;
			p.plane2_normal_z = p.plane2_normal_z >>> sh;
			p.plane3_normal_x = p.plane3_normal_x >>> sh;
			p.plane3_normal_y = p.plane3_normal_y >>> sh;
			p.plane3_normal_z = p.plane3_normal_z >>> sh;
		end
		7: begin
			p.plane3_normal_x = p.plane1_normal_x;
			p.plane3_normal_y = p.plane1_normal_y;
			p.plane3_normal_z = p.plane1_normal_z;
		end
		8: begin
			p = axis_planes($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384,
				$urandom, $urandom, $urandom);
			p.plane1_normal_y = $signed(16'($urandom_range(0, 255))) - 16'sd128;
			p.plane2_normal_z = $signed(16'($urandom_range(0, 255))) - 16'sd128;
		end
		9: begin
			p = axis_planes($signed(16'($urandom_range(0, 8))) - 16'sd4,
				$urandom, $urandom, $urandom);
			p.plane3_normal_x = $signed(16'($urandom_range(0, 2))) - 16'sd1;
		end
		default: ;
		endcase
		return p;
	endfunction

	task automatic send_planes(input plane_set_t p, input bit typed, input result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid = 1'b1;
		req.data = p;
		do
			@(posedge clk);
		while (!req.ready);
		pending_points.push_back(typed ? want : solve_planes(p, threshold));
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		threshold = value;
	endtask

	always @(posedge clk) begin
		result_t want;
		if (req.valid && req.ready || rsp.valid && rsp.ready)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result transfer");
				mismatches++;
			end else begin
				want = pending_points.pop_front();
				if (rsp.data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp.data.found);
					mismatches++;
				end
				if (rsp.data.point_x !== want.point_x) begin
					$error("point_x: expected %0d, got %0d", want.point_x, rsp.data.point_x);
					mismatches++;
				end
				if (rsp.data.point_y !== want.point_y) begin
					$error("point_y: expected %0d, got %0d", want.point_y, rsp.data.point_y);
					mismatches++;
				end
				if (rsp.data.point_z !== want.point_z) begin
					$error("point_z: expected %0d, got %0d", want.point_z, rsp.data.point_z);
					mismatches++;
				end
				if (rsp.data.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated,
						rsp.data.saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int gap;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_rsp = 0;
				rsp.ready = 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end
			gap = pick_gap();
			if (gap > 0) begin
				rsp.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready = 1'b1;
		end
	end

	initial begin
		row_t rows[$];
		row_t row;
		result_t none;
		result_t pt;
		logic [THR_W-1:0] settings[5];
		req.valid = 1'b0;
		req.data = '0;
		none = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		row = '{planes: '0, typed: 1, want: none};
		rows.push_back(row);
		row.planes = {3{16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000}};
		rows.push_back(row);
		row.planes = axis_planes(16'sd16384, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1);
		pt = '{found: 1'b1, point_x: 32'sh7FFFFFFF, point_y: 32'sh80000000,
			point_z: 32'sd1, saturated: 1'b0};
		row.want = pt;
		rows.push_back(row);
		row.planes = axis_planes(16'sd16384, 32'sd65536, -32'sd65536, 32'sd0);
		row.want = '{found: 1'b1, point_x: 32'sd65536, point_y: -32'sd65536,
			point_z: 32'sd0, saturated: 1'b0};
		rows.push_back(row);
		row.typed = 0;
		row.planes = axis_planes(-16'sd16384, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1);
		rows.push_back(row);
		row.planes = axis_planes(16'sh7FFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
		rows.push_back(row);
		row.planes = axis_planes(16'sh8000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
		rows.push_back(row);
		row.planes = axis_planes(16'sd3, 32'sh7FFFFFFF, -32'sd5, 32'sd5);
		rows.push_back(row);
		row.planes = axis_planes(16'sd1, 32'sd1, -32'sd1, 32'sd0);
		rows.push_back(row);
		row.planes = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'sh7FFFFFFF,
			16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'sh80000000,
			16'sh7FFF, 16'sh7FFF, 16'sh8000, 32'sh7FFFFFFF};
		rows.push_back(row);
		row.planes = {16'sd16384, 16'sd16384, 16'sd0, 32'sd65536,
			16'sd0, 16'sd16384, 16'sd16384, 32'sd131072,
			16'sd16384, 16'sd0, 16'sd16384, -32'sd98304};
		rows.push_back(row);
		repeat (12) begin
			row.planes = random_planes();
			rows.push_back(row);
		end

		foreach (rows[i])
			send_planes(rows[i].planes, rows[i].typed, rows[i].want);
		drain();

		settings = '{32'd0, THR_MAX, $urandom, 32'd1, THR_RESET};
		foreach (settings[k]) begin
			write_threshold(settings[k]);
			if (k == 1)
				hold_rsp = 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_planes(random_planes(), 0, none);
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: three_plane_intersection_core.f
+incdir+rtl
rtl/tpi_pkg.sv
rtl/tpi_if.sv
rtl/tpi_front.sv
rtl/tpi_div.sv
rtl/three_plane_intersection_core.sv
sim/three_plane_intersection_core_tb.sv
